// File: rtl/gdd_pkg.sv
// Shared widths, result types and calendar helper functions for the date difference block.
package gdd_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MON_W   = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned DIFF_W  = 23;
  localparam int unsigned WDAY_W  = 3;
  localparam int unsigned QUO_W   = 8;   // year / 100 for a 14-bit year
  localparam int unsigned REM_W   = 7;   // year % 100
  localparam int unsigned MS_W    = 9;   // days before a month start
  localparam int unsigned ZM_W    = 6;   // Zeller month term
  localparam int unsigned ZSUM_W  = 11;  // Zeller sum before mod 7
  localparam int unsigned YCMP_W  = 17;  // compare width for the year limit

  localparam int unsigned MaxYear = 9999;

  // x / 100 as (x * 5243) >> 19, exact for any 14-bit x
  localparam int unsigned Div100Mul = 5243;
  localparam int unsigned Div100Sh  = 19;
  localparam int unsigned Div100PW  = YEAR_W + 13;

  // s / 7 as (s * 2341) >> 14, exact for any 11-bit s
  localparam int unsigned Div7Mul = 2341;
  localparam int unsigned Div7Sh  = 14;
  localparam int unsigned Div7PW  = Div7Sh + ZSUM_W;

  localparam logic [MON_W-1:0] MonFeb = MON_W'(2);

  typedef struct packed {
    logic              valid;
    logic [DIFF_W-1:0] day_num;
    logic [WDAY_W-1:0] weekday;
  } date_info_t;

  function automatic logic [QUO_W-1:0] div100(input logic [YEAR_W-1:0] x);
    logic [Div100PW-1:0] prod;
    prod = Div100PW'(x) * Div100PW'(Div100Mul);
    return prod[Div100Sh +: QUO_W];
  endfunction

  function automatic logic [MS_W-1:0] month_start(input logic [MON_W-1:0] m);
    logic [MS_W-1:0] r;
    case (m)
      4'd1:    r = MS_W'(0);
      4'd2:    r = MS_W'(31);
      4'd3:    r = MS_W'(59);
      4'd4:    r = MS_W'(90);
      4'd5:    r = MS_W'(120);
      4'd6:    r = MS_W'(151);
      4'd7:    r = MS_W'(181);
      4'd8:    r = MS_W'(212);
      4'd9:    r = MS_W'(243);
      4'd10:   r = MS_W'(273);
      4'd11:   r = MS_W'(304);
      4'd12:   r = MS_W'(334);
      default: r = MS_W'(0);
    endcase
    return r;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m);
    logic [DAY_W-1:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = DAY_W'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                    r = DAY_W'(30);
      4'd2:                                       r = DAY_W'(28);
      default:                                    r = DAY_W'(0);
    endcase
    return r;
  endfunction

  // (13 * (m + 1)) / 5 for the shifted month 3..14
  function automatic logic [ZM_W-1:0] zeller_month(input logic [MON_W-1:0] m);
    logic [ZM_W-1:0] r;
    case (m)
      4'd3:    r = ZM_W'(10);
      4'd4:    r = ZM_W'(13);
      4'd5:    r = ZM_W'(15);
      4'd6:    r = ZM_W'(18);
      4'd7:    r = ZM_W'(20);
      4'd8:    r = ZM_W'(23);
      4'd9:    r = ZM_W'(26);
      4'd10:   r = ZM_W'(28);
      4'd11:   r = ZM_W'(31);
      4'd12:   r = ZM_W'(33);
      4'd13:   r = ZM_W'(36);
      4'd14:   r = ZM_W'(39);
      default: r = ZM_W'(0);
    endcase
    return r;
  endfunction

  function automatic logic [WDAY_W-1:0] mod7(input logic [ZSUM_W-1:0] s);
    logic [Div7PW-1:0] prod;
    logic [ZSUM_W-1:0] q;
    logic [ZSUM_W-1:0] r;
    prod = Div7PW'(s) * Div7PW'(Div7Mul);
    q    = prod[Div7Sh +: ZSUM_W];
    r    = s - ZSUM_W'(q * ZSUM_W'(7));
    return r[WDAY_W-1:0];
  endfunction

endpackage

// File: rtl/gdd_date_unit.sv
// Validity check, day number and Zeller weekday of one calendar date.
module gdd_date_unit (
  input  logic [gdd_pkg::DAY_W-1:0]  day,
  input  logic [gdd_pkg::MON_W-1:0]  month,
  input  logic [gdd_pkg::YEAR_W-1:0] year,
  output gdd_pkg::date_info_t        info
);

  localparam int unsigned YW = gdd_pkg::YEAR_W;
  localparam int unsigned QW = gdd_pkg::QUO_W;
  localparam int unsigned RW = gdd_pkg::REM_W;
  localparam int unsigned NW = gdd_pkg::DIFF_W;
  localparam int unsigned SW = gdd_pkg::ZSUM_W;

  logic [YW-1:0] prev_year;
  logic [QW-1:0] q_year;
  logic [QW-1:0] q_prev;
  logic [YW-1:0] rem_full;
  logic [RW-1:0] rem_year;
  logic          leap;
  logic          year_ok;
  logic          month_ok;
  logic          day_ok;
  logic [gdd_pkg::DAY_W-1:0] len;

  logic          early;
  logic [gdd_pkg::MON_W-1:0] z_month;
  logic [YW-1:0] z_year;
  logic [QW-1:0] z_cent;
  logic [YW-1:0] z_rem_full;
  logic [RW-1:0] z_rem;
  logic [SW-1:0] z_sum;

  assign prev_year = year - YW'(1);
  assign q_year    = gdd_pkg::div100(year);
  assign q_prev    = gdd_pkg::div100(prev_year);
  assign rem_full  = year - YW'(YW'(q_year) * YW'(100));
  assign rem_year  = rem_full[RW-1:0];

  // divisible by 4 and not by 100, or by 400 (century count a multiple of 4)
  assign leap = (year[1:0] == 2'd0 && rem_year != '0) ||
                (rem_year == '0 && q_year[1:0] == 2'd0);

  assign year_ok  = (year != '0) &&
                    (gdd_pkg::YCMP_W'(year) <= gdd_pkg::YCMP_W'(gdd_pkg::MaxYear));
  assign month_ok = month inside {[4'd1:4'd12]};
  assign len      = (month == gdd_pkg::MonFeb && leap) ? gdd_pkg::DAY_W'(29)
                                                       : gdd_pkg::month_len(month);
  assign day_ok   = (day != '0) && (day <= len);

  assign info.valid = year_ok && month_ok && day_ok;

  // days since the day before 1 January of year 1
  assign info.day_num = NW'(NW'(prev_year) * NW'(365))
                      + NW'(prev_year[YW-1:2])
                      - NW'(q_prev)
                      + NW'(q_prev[QW-1:2])
                      + NW'(gdd_pkg::month_start(month))
                      + NW'(month > gdd_pkg::MonFeb && leap)
                      + NW'(day);

  // January and February count as months 13 and 14 of the year before
  assign early      = month inside {[4'd0:4'd2]};
  assign z_month    = early ? month + gdd_pkg::MON_W'(12) : month;
  assign z_year     = early ? prev_year : year;
  assign z_cent     = early ? q_prev : q_year;
  assign z_rem_full = z_year - YW'(YW'(z_cent) * YW'(100));
  assign z_rem      = z_rem_full[RW-1:0];

  assign z_sum = SW'(day)
               + SW'(gdd_pkg::zeller_month(z_month))
               + SW'(z_rem)
               + SW'(z_rem[RW-1:2])
               + SW'(z_cent[QW-1:2])
               + SW'(SW'(z_cent) * SW'(5));

  assign info.weekday = gdd_pkg::mod7(z_sum);

endmodule

// File: rtl/gregorian_date_difference.sv
// Top level: request register, two date units and the result register.
// A request is taken into the request register; its result and result strobe then come from the result register.
// Throughput: one request per cycle; busy is never raised and the receiver cannot stall.
// The per-date validity, day number and weekday logic sets the path between the two registers.
// Reset (rst_n low, synchronous) clears the pending request and the result strobe.
module gregorian_date_difference (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [gdd_pkg::DAY_W-1:0]           in_start_day,
  input  logic [gdd_pkg::MON_W-1:0]           in_start_month,
  input  logic [gdd_pkg::YEAR_W-1:0]          in_start_year,
  input  logic [gdd_pkg::DAY_W-1:0]           in_end_day,
  input  logic [gdd_pkg::MON_W-1:0]           in_end_month,
  input  logic [gdd_pkg::YEAR_W-1:0]          in_end_year,
  output logic                                out_valid,
  output logic                                out_start_valid,
  output logic                                out_end_valid,
  output logic signed [gdd_pkg::DIFF_W-1:0]   out_day_difference,
  output logic [gdd_pkg::WDAY_W-1:0]          out_start_weekday
);

  logic                          req_vld_r;
  logic [gdd_pkg::DAY_W-1:0]     s_day_r;
  logic [gdd_pkg::MON_W-1:0]     s_month_r;
  logic [gdd_pkg::YEAR_W-1:0]    s_year_r;
  logic [gdd_pkg::DAY_W-1:0]     e_day_r;
  logic [gdd_pkg::MON_W-1:0]     e_month_r;
  logic [gdd_pkg::YEAR_W-1:0]    e_year_r;

  gdd_pkg::date_info_t           s_info;
  gdd_pkg::date_info_t           e_info;

  logic                          res_vld_r;
  logic                          res_s_ok_r;
  logic                          res_e_ok_r;
  logic [gdd_pkg::DIFF_W-1:0]    res_diff_r;
  logic [gdd_pkg::DIFF_W-1:0]    res_diff_nxt;
  logic [gdd_pkg::WDAY_W-1:0]    res_wday_r;
  logic [gdd_pkg::WDAY_W-1:0]    res_wday_nxt;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else begin
      req_vld_r <= start;
    end
  end

  // hold the request fields until the next request
  always_ff @(posedge clk) begin
    if (start) begin
      s_day_r   <= in_start_day;
      s_month_r <= in_start_month;
      s_year_r  <= in_start_year;
      e_day_r   <= in_end_day;
      e_month_r <= in_end_month;
      e_year_r  <= in_end_year;
    end
  end

  gdd_date_unit u_start_date (
    .day   (s_day_r),
    .month (s_month_r),
    .year  (s_year_r),
    .info  (s_info)
  );

  gdd_date_unit u_end_date (
    .day   (e_day_r),
    .month (e_month_r),
    .year  (e_year_r),
    .info  (e_info)
  );

  // drop the difference unless both dates are valid, and the weekday unless the start date is
  assign res_diff_nxt = (s_info.valid && e_info.valid) ? e_info.day_num - s_info.day_num
                                                       : '0;
  assign res_wday_nxt = s_info.valid ? s_info.weekday : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else begin
      res_vld_r <= req_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (req_vld_r) begin
      res_s_ok_r <= s_info.valid;
      res_e_ok_r <= e_info.valid;
      res_diff_r <= res_diff_nxt;
      res_wday_r <= res_wday_nxt;
    end
  end

  assign out_valid          = res_vld_r;
  assign out_start_valid    = res_s_ok_r;
  assign out_end_valid      = res_e_ok_r;
  assign out_day_difference = $signed(res_diff_r);
  assign out_start_weekday  = res_wday_r;

endmodule

// File: verif/tb.sv
// Self-checking testbench for the Gregorian date difference block.
`timescale 1ns / 100ps

module tb;
  import gdd_pkg::*;

  localparam int unsigned STALL_LIMIT = 200;
  localparam int unsigned RANDOM_REQS = 740;
  localparam int unsigned MAX_GAP     = 8;

  typedef struct packed {
    logic [DAY_W-1:0]  s_day;
    logic [MON_W-1:0]  s_mon;
    logic [YEAR_W-1:0] s_year;
    logic [DAY_W-1:0]  e_day;
    logic [MON_W-1:0]  e_mon;
    logic [YEAR_W-1:0] e_year;
  } date_pair_t;

  localparam int unsigned PAIR_W = $bits(date_pair_t);

  typedef struct packed {
    logic                     s_ok;
    logic                     e_ok;
    logic signed [DIFF_W-1:0] span;
    logic [WDAY_W-1:0]        wday;
  } span_result_t;

  class span_tracker;
    span_result_t awaited[$];
    int unsigned  mismatches;

    function bit is_leap_year(int y);
      return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function int days_in_month(int m, int y);
      case (m)
        2:           return is_leap_year(y) ? 29 : 28;
        4, 6, 9, 11: return 30;
        default:     return 31;
      endcase
    endfunction

    function bit date_is_real(int d, int m, int y);
      if (y < 1 || y > int'(MaxYear)) return 1'b0;
      if (m < 1 || m > 12) return 1'b0;
      return d >= 1 && d <= days_in_month(m, y);
    endfunction

    // Days counted from 1 January of year 1, which is day 1.
    function int day_ordinal(int d, int m, int y);
      int p;
      int n;
      p = y - 1;
      n = 365 * p + p / 4 - p / 100 + p / 400 + d;
      for (int i = 1; i < m; i++) n += days_in_month(i, y);
      return n;
    endfunction

    // Zeller: January and February count as months 13 and 14 of the prior year.
    function int zeller_day(int d, int m, int y);
      int k;
      int j;
      if (m <= 2) begin
        m += 12;
        y -= 1;
      end
      k = y % 100;
      j = y / 100;
      return (d + (13 * (m + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7;
    endfunction

    function void note_request(date_pair_t r);
      span_result_t e;
      e.s_ok = date_is_real(r.s_day, r.s_mon, r.s_year);
      e.e_ok = date_is_real(r.e_day, r.e_mon, r.e_year);
      e.span = '0;
      e.wday = '0;
      if (e.s_ok && e.e_ok)
        e.span = DIFF_W'(day_ordinal(r.e_day, r.e_mon, r.e_year) -
                         day_ordinal(r.s_day, r.s_mon, r.s_year));
      if (e.s_ok) e.wday = WDAY_W'(zeller_day(r.s_day, r.s_mon, r.s_year));
      awaited.push_back(e);
    endfunction

    function void check_result(span_result_t got);
      span_result_t e;
      if (awaited.size() == 0) begin
        mismatches++;
        $error("result strobe with no request pending");
        return;
      end
      e = awaited.pop_front();
      if (got.s_ok !== e.s_ok) begin
        mismatches++;
        $error("start_valid: expected %0d, got %0d", e.s_ok, got.s_ok);
      end
      if (got.e_ok !== e.e_ok) begin
        mismatches++;
        $error("end_valid: expected %0d, got %0d", e.e_ok, got.e_ok);
      end
      if (got.span !== e.span) begin
        mismatches++;
        $error("day_difference: expected %0d, got %0d", e.span, got.span);
      end
      if (got.wday !== e.wday) begin
        mismatches++;
        $error("start_weekday: expected %0d, got %0d", e.wday, got.wday);
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [DAY_W-1:0]         in_start_day;
  logic [MON_W-1:0]         in_start_month;
  logic [YEAR_W-1:0]        in_start_year;
  logic [DAY_W-1:0]         in_end_day;
  logic [MON_W-1:0]         in_end_month;
  logic [YEAR_W-1:0]        in_end_year;
  logic                     out_valid;
  logic                     out_start_valid;
  logic                     out_end_valid;
  logic signed [DIFF_W-1:0] out_day_difference;
  logic [WDAY_W-1:0]        out_start_weekday;

  span_tracker book = new();
  int unsigned quiet_cycles = 0;

  date_pair_t corner_cases[$] = '{
    '{1, 1, 1, 31, 12, 9999},
    '{31, 12, 9999, 1, 1, 1},
    '{29, 2, 2000, 1, 3, 2000},
    '{29, 2, 1900, 1, 1, 1900},
    '{28, 2, 2100, 29, 2, 2100},
    '{29, 2, 2024, 29, 2, 2023},
    '{15, 6, 0, 15, 6, 1},
    '{1, 1, 10000, 1, 1, 9999},
    '{31, 15, 16383, 31, 15, 16383},
    '{0, 0, 0, 0, 0, 0},
    '{1, 0, 2000, 1, 13, 2000},
    '{0, 3, 2001, 31, 4, 2001},
    '{30, 4, 2001, 31, 1, 2001},
    '{31, 3, 1999, 31, 3, 1999},
    '{1, 2, 1, 28, 2, 1},
    '{1, 1, 2000, 7, 1, 2000},
    '{31, 12, 1600, 1, 1, 1601},
    '{29, 2, 400, 28, 2, 401},
    '{15, 14, 5000, 15, 8, 5000},
    '{1, 1, 8191, 1, 1, 8192}
  };

  gregorian_date_difference i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_start_day       (in_start_day),
    .in_start_month     (in_start_month),
    .in_start_year      (in_start_year),
    .in_end_day         (in_end_day),
    .in_end_month       (in_end_month),
    .in_end_year        (in_end_year),
    .out_valid          (out_valid),
    .out_start_valid    (out_start_valid),
    .out_end_valid      (out_end_valid),
    .out_day_difference (out_day_difference),
    .out_start_weekday  (out_start_weekday)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      book.check_result(span_result_t'{out_start_valid, out_end_valid,
                                       out_day_difference, out_start_weekday});
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic void pick_real_date(output int d, output int m, output int y);
    case ($urandom_range(9))
      0:       y = 1;
      1:       y = MaxYear;
      2:       y = 400 * $urandom_range(1, 24);
      3:       y = 100 * $urandom_range(1, 99);
      default: y = $urandom_range(1, MaxYear);
    endcase
    m = $urandom_range(1, 12);
    if ($urandom_range(4) == 0) d = book.days_in_month(m, y);
    else d = $urandom_range(1, book.days_in_month(m, y));
  endfunction

  function automatic void pick_noise_date(output int d, output int m, output int y);
    d = $urandom_range(31);
    m = $urandom_range(15);
    y = $urandom_range((1 << YEAR_W) - 1);
  endfunction

  function automatic date_pair_t random_pair();
    date_pair_t r;
    int sd, sm, sy, ed, em, ey;
    int pick;
    pick = $urandom_range(99);
    if (pick < 90) pick_real_date(sd, sm, sy);
    else pick_noise_date(sd, sm, sy);
    if (pick >= 78 && pick < 90) begin
      pick_noise_date(ed, em, ey);
    end else begin
      pick_real_date(ed, em, ey);
      // keep some spans short: same year as the start
      if ($urandom_range(2) == 0 && pick < 78) begin
        ey = sy;
        ed = $urandom_range(1, book.days_in_month(em, ey));
      end
    end
    r = '{DAY_W'(sd), MON_W'(sm), YEAR_W'(sy), DAY_W'(ed), MON_W'(em), YEAR_W'(ey)};
    return r;
  endfunction

  task automatic issue(input date_pair_t r);
    {in_start_day, in_start_month, in_start_year,
     in_end_day, in_end_month, in_end_year} <= r;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    book.note_request(r);
  endtask

  task automatic rest(input bit calm);
    int gaps;
    gaps = 0;
    if (!calm)
      while (gaps < MAX_GAP && $urandom_range(99) < 36) gaps++;
    if (gaps > 0) begin
      start <= 1'b0;
      // scramble the payload while idle; the block must ignore it
      {in_start_day, in_start_month, in_start_year,
       in_end_day, in_end_month, in_end_year} <= PAIR_W'({$urandom, $urandom});
      repeat (gaps) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (book.awaited.size() != 0) @(posedge clk);
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    {in_start_day, in_start_month, in_start_year,
     in_end_day, in_end_month, in_end_year} <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (corner_cases[i]) begin
      issue(corner_cases[i]);
      rest(1'b0);
    end
    drain();

    for (int n = 0; n < RANDOM_REQS; n++) begin
      issue(random_pair());
      if (n == 550) drain();
      rest(n >= 300 && n < 420);
    end

    drain();
    repeat (4) @(posedge clk);
    if (book.mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: sim.f
rtl/gdd_pkg.sv
rtl/gdd_date_unit.sv
rtl/gregorian_date_difference.sv
verif/tb.sv
